### hw/rtl/baro_altitude_vertical_speed_unit_defines.svh
// Assertion macros shared by the RTL
`ifndef BARO_ALTITUDE_VERTICAL_SPEED_UNIT_DEFINES_SVH
`define BARO_ALTITUDE_VERTICAL_SPEED_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BAVS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
`define BAVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("%m failed");
`else
`define BAVS_ASSERT(lbl, clk, rst, prop)
`define BAVS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/bavs_pkg.sv
`timescale 1ns / 1ps
package bavs_pkg;

  localparam int POW_TABLE_ENTRIES = 256;
  localparam int RATIO_FRAC_BITS   = 16;
  localparam int EXP_NUM           = 1903;
  localparam int EXP_DEN           = 10000;
  localparam int ALT_SCALE_Q4      = 709280;
  localparam int DIV_W             = 37;
  localparam int DIV_CNT_W         = 6;

  localparam logic [16:0] SLP_RESET = 17'd101520;
  localparam logic [15:0] MIN_INTERVAL_RESET = 16'd45;
  localparam logic [16:0] RATIO_MAX = 17'h1FFFF;
  localparam logic signed [18:0] FAIL_ALT_Q4 = -19'sd16;
  localparam logic signed [18:0] ALT_MIN = -19'sd65536;
  localparam logic signed [18:0] ALT_MAX = 19'sd262143;
  localparam logic signed [19:0] VEL_MIN = -20'sd524288;
  localparam logic signed [19:0] VEL_MAX = 20'sd524287;

  localparam logic [1:0] REG_SEA_LEVEL_PRESSURE = 2'd0;
  localparam logic [1:0] REG_MIN_INTERVAL_MS    = 2'd1;

  typedef logic [16:0] pow_rom_t [0:POW_TABLE_ENTRIES];

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_RDIV, ST_LOOK, ST_INTERP, ST_MUL,
    ST_ALT, ST_VMUL, ST_VDIV, ST_VEL, ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic sel_vel;
    logic lookup;
    logic interp;
    logic mult;
    logic alt_fin;
    logic vmul;
    logic vel_fin;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic held;
    logic failed;
    logic dt_zero;
    logic div_done;
  } status_t;

  function automatic longint log2_q30(longint unsigned v);
    int k;
    longint unsigned m;
    longint res;
    k = 0;
    while (k < 31 && (v >> (k + 1)) != 0) k++;
    m = v << (30 - k);
    res = longint'(k) <<< 30;
    for (int b = 29; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        res = res | (64'sd1 <<< b);
      end
    end
    return res;
  endfunction

  function automatic longint unsigned isqrt64(longint unsigned xin);
    longint unsigned x;
    longint unsigned res;
    longint unsigned bitv;
    x = xin;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // (2i/N)^0.1903 in Q16 via log2 / exp2 on Q30
  function automatic pow_rom_t build_pow_rom();
    pow_rom_t rom;
    longint unsigned roots [0:30];
    longint log_n;
    longint l;
    longint e;
    longint ep;
    longint unsigned frac;
    longint unsigned acc;
    longint unsigned sum;
    int ip;
    int s;
    roots[0] = 0;
    log_n = log2_q30(longint'(POW_TABLE_ENTRIES));
    roots[1] = isqrt64(64'd1 << 61);
    for (int k = 2; k <= 30; k++) roots[k] = isqrt64(roots[k-1] << 30);
    rom[0] = '0;
    for (int i = 1; i <= POW_TABLE_ENTRIES; i++) begin
      l = log2_q30(longint'(2 * i)) - log_n;
      if (l >= 0) e = (l * EXP_NUM) / EXP_DEN;
      else e = -(((-l) * EXP_NUM + (EXP_DEN - 1)) / EXP_DEN);
      ep = e + (64'sd8 <<< 30);
      ip = int'(ep >>> 30);
      frac = longint'(ep) & ((64'd1 << 30) - 1);
      acc = 64'd1 << 30;
      for (int k = 1; k <= 30; k++)
        if (((frac >> (30 - k)) & 64'd1) != 0) acc = (acc * roots[k]) >> 30;
      s = 22 - ip;
      if (s < 1) s = 1;
      if (s > 62) s = 62;
      sum = (acc + (64'd1 << (s - 1))) >> s;
      rom[i] = sum[16:0];
    end
    return rom;
  endfunction

  localparam pow_rom_t POW_ROM = build_pow_rom();

endpackage

### hw/rtl/baro_altitude_vertical_speed_unit.sv
`timescale 1ns / 1ps
// Barometric altitude and vertical speed. One request is taken at a time;
// a fresh request runs two restoring divides in a shared divider, pressure
// ratio then velocity; a failed read skips the ratio divide, and a request
// inside the minimum interval skips both. Zero elapsed time skips the
// velocity divide. The controller can take the next request as soon as the
// result is registered. The result sits in an output register, so the next
// request is accepted while it waits to be taken.
`include "baro_altitude_vertical_speed_unit_defines.svh"
module baro_altitude_vertical_speed_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [16:0] cfg_data,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [55:0] s_tdata,  // pressure_q4[20:0], timestamp_ms[52:21], zero pad
  input  logic s_tuser,         // read_failed
  output logic m_tvalid,
  input  logic m_tready,
  output logic [39:0] m_tdata,  // altitude_q4[18:0], velocity_q4[38:19], zero pad
  output logic m_tuser          // fresh
);
  import bavs_pkg::*;

  cmd_t cmd;
  status_t status;
  logic signed [18:0] altitude_q4;
  logic signed [19:0] velocity_q4;

  bavs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .status(status), .cmd(cmd)
  );

  bavs_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pressure_q4(s_tdata[20:0]), .timestamp_ms(s_tdata[52:21]),
    .read_failed(s_tuser),
    .altitude_q4(altitude_q4), .velocity_q4(velocity_q4), .fresh(m_tuser)
  );

  assign m_tdata = {1'b0, velocity_q4, altitude_q4};

  `BAVS_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
  `BAVS_ASSERT(a_single_cmd_start, clk, rst, !(cmd.div_start && status.div_done))
  `BAVS_ASSERT_NEXT(a_commit_shows, clk, rst, cmd.commit, m_tvalid)
endmodule

### hw/rtl/bavs_div.sv
`timescale 1ns / 1ps
module bavs_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [bavs_pkg::DIV_W-1:0] num,
  input  logic [31:0] den,
  output logic [bavs_pkg::DIV_W-1:0] quo,
  output logic done
);
  import bavs_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0] rem;
  logic [32:0] shifted;
  logic ge;

  assign shifted = {rem, quo[DIV_W-1]};
  assign ge = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DIV_CNT_W'(DIV_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) done <= 1'b1;
      end
    end
  end

  // restoring, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (cnt != '0) begin
      rem <= ge ? 32'(shifted - {1'b0, den}) : shifted[31:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end
endmodule

### hw/rtl/bavs_dp.sv
`timescale 1ns / 1ps
module bavs_dp (
  input  logic clk,
  input  logic rst,
  input  bavs_pkg::cmd_t cmd,
  output bavs_pkg::status_t status,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [16:0] cfg_data,
  input  logic [20:0] pressure_q4,
  input  logic [31:0] timestamp_ms,
  input  logic read_failed,
  output logic signed [18:0] altitude_q4,
  output logic signed [19:0] velocity_q4,
  output logic fresh
);
  import bavs_pkg::*;

  logic [16:0] sea_level_pressure;
  logic [15:0] min_interval_ms;
  logic signed [18:0] prev_altitude;
  logic [31:0] prev_time;
  logic signed [19:0] held_velocity;

  logic [20:0] p_r;
  logic [31:0] t_r;
  logic fail_r;
  logic [31:0] dt_r;
  logic [16:0] t0, t1, w_r;
  logic [17:0] y_r;
  logic signed [40:0] prod_r;
  logic signed [18:0] alt_r;
  logic signed [29:0] vprod_r;
  logic signed [19:0] vel_r;

  logic [DIV_W-1:0] div_num, quo;
  logic [31:0] div_den;
  logic div_done;
  logic [16:0] ratio;
  logic [7:0] idx;
  logic [16:0] diff;
  logic [33:0] dprod;
  logic signed [18:0] ym;
  logic signed [24:0] rounded;
  logic signed [19:0] adiff;
  logic [29:0] vmag;
  logic [29:0] q;
  logic signed [19:0] vsat;

  always_ff @(posedge clk) begin
    if (rst) begin
      sea_level_pressure <= SLP_RESET;
      min_interval_ms <= MIN_INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEA_LEVEL_PRESSURE: sea_level_pressure <= cfg_data;
        REG_MIN_INTERVAL_MS:    min_interval_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign vmag = vprod_r[29] ? 30'(-vprod_r) : 30'(vprod_r);
  assign div_num = cmd.sel_vel ? {7'd0, vmag} : {p_r, 16'd0};
  assign div_den = cmd.sel_vel ? dt_r : {11'd0, sea_level_pressure, 4'd0};

  bavs_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .num(div_num), .den(div_den), .quo(quo), .done(div_done)
  );

  assign status.held = dt_r < {16'd0, min_interval_ms};
  assign status.failed = fail_r;
  assign status.dt_zero = dt_r == '0;
  assign status.div_done = div_done;

  assign ratio = (|quo[DIV_W-1:17]) ? RATIO_MAX : quo[16:0];
  assign idx = ratio[16:9];
  assign diff = t1 - t0;
  assign dprod = 34'(diff) * 34'(w_r);
  assign ym = 19'sd65536 - $signed({1'b0, y_r});
  assign rounded = 25'((prod_r + 41'sd32768) >>> 16);
  assign adiff = {alt_r[18], alt_r} - {prev_altitude[18], prev_altitude};
  assign q = quo[29:0];

  always_comb begin
    if (vprod_r[29]) begin
      if (q > 30'd524288) vsat = VEL_MIN;
      else vsat = 20'(-$signed({1'b0, q[19:0]}));
    end else begin
      if (q > 30'd524287) vsat = VEL_MAX;
      else vsat = $signed(q[19:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      p_r <= pressure_q4;
      t_r <= timestamp_ms;
      fail_r <= read_failed;
      dt_r <= timestamp_ms - prev_time;
    end
    if (cmd.lookup) begin
      t0 <= POW_ROM[{1'b0, idx}];
      t1 <= POW_ROM[{1'b0, idx} + 9'd1];
      w_r <= {ratio[8:0], 8'd0};
    end
    if (cmd.interp) y_r <= {1'b0, t0} + {1'b0, dprod[33:17]};
    if (cmd.mult) prod_r <= $signed(22'sd709280) * ym;
    if (cmd.alt_fin) begin
      if (fail_r) alt_r <= FAIL_ALT_Q4;
      else if (rounded < 25'(ALT_MIN)) alt_r <= ALT_MIN;
      else if (rounded > 25'(ALT_MAX)) alt_r <= ALT_MAX;
      else alt_r <= rounded[18:0];
    end
    if (cmd.vmul) vprod_r <= 30'(adiff) * 30'sd1000;
    if (cmd.vel_fin) vel_r <= status.dt_zero ? '0 : vsat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_altitude <= '0;
      prev_time <= '0;
      held_velocity <= '0;
    end else if (cmd.commit && !status.held) begin
      prev_altitude <= alt_r;
      prev_time <= t_r;
      held_velocity <= vel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      altitude_q4 <= status.held ? prev_altitude : alt_r;
      velocity_q4 <= status.held ? held_velocity : vel_r;
      fresh <= !status.held;
    end
  end
endmodule

### hw/rtl/bavs_ctrl.sv
`timescale 1ns / 1ps
module bavs_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  bavs_pkg::status_t status,
  output bavs_pkg::cmd_t cmd
);
  import bavs_pkg::*;

  state_t state, state_next;
  logic out_free;
  // high in the first cycle of ST_VDIV, once the product register has loaded
  logic vdiv_go;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      vdiv_go <= 1'b0;
    end else begin
      state <= state_next;
      vdiv_go <= (state == ST_VMUL) && !status.dt_zero;
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status.held) state_next = ST_DONE;
        else if (status.failed) state_next = ST_ALT;
        else begin
          cmd.div_start = 1'b1;
          state_next = ST_RDIV;
        end
      end
      ST_RDIV: if (status.div_done) state_next = ST_LOOK;
      ST_LOOK: begin
        cmd.lookup = 1'b1;
        state_next = ST_INTERP;
      end
      ST_INTERP: begin
        cmd.interp = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mult = 1'b1;
        state_next = ST_ALT;
      end
      ST_ALT: begin
        cmd.alt_fin = 1'b1;
        state_next = ST_VMUL;
      end
      ST_VMUL: begin
        cmd.vmul = 1'b1;
        state_next = status.dt_zero ? ST_VEL : ST_VDIV;
      end
      ST_VDIV: begin
        cmd.sel_vel = 1'b1;
        cmd.div_start = vdiv_go;
        if (status.div_done) state_next = ST_VEL;
      end
      ST_VEL: begin
        cmd.sel_vel = 1'b1;
        cmd.vel_fin = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bavs_pkg::*;

  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 155;

  typedef struct packed {
    logic signed [18:0] alt;
    logic signed [19:0] vel;
    logic               fresh;
  } alt_result_t;

  typedef struct {
    logic [20:0]        p;
    logic [31:0]        t;
    logic               failed;
    logic               typed;
    logic signed [18:0] alt;
    logic signed [19:0] vel;
    logic               fresh;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [55:0] s_tdata = '0;  // pressure_q4[20:0], timestamp_ms[52:21], zero pad
  logic s_tuser = 1'b0;       // read_failed
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;       // altitude_q4[18:0], velocity_q4[38:19], zero pad
  logic m_tuser;              // fresh

  baro_altitude_vertical_speed_unit i_dut (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // predictor state
  longint unsigned pow_q16 [0:POW_TABLE_ENTRIES];
  logic [16:0] slp_pa = SLP_RESET;
  logic [15:0] min_gap_ms = MIN_INTERVAL_RESET;
  logic signed [18:0] last_alt = '0;
  logic [31:0] last_time = '0;
  logic signed [19:0] last_vel = '0;

  alt_result_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int fresh_seen = 0;
  int held_seen = 0;
  int stall_hold = 0;
  bit no_idle = 1'b0;

  function automatic longint q30_log2(longint unsigned v);
    int k;
    longint unsigned m;
    longint res;
    k = 0;
    while (k < 31 && (v >> (k + 1)) != 0) k++;
    m = v << (30 - k);
    res = longint'(k) <<< 30;
    for (int b = 29; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        res = res | (64'sd1 <<< b);
      end
    end
    return res;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned xin);
    longint unsigned x;
    longint unsigned res;
    longint unsigned bv;
    x = xin;
    res = 0;
    bv = 64'd1 << 62;
    while (bv > x) bv = bv >> 2;
    while (bv != 0) begin
      if (x >= res + bv) begin
        x = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // (2i/N)^0.1903 in Q16: log2, scale exponent, exp2 from chained square roots of 2
  function automatic void fill_pow_table();
    longint unsigned roots [1:30];
    longint log_n;
    longint l;
    longint e;
    longint ep;
    longint unsigned frac;
    longint unsigned acc;
    int ip;
    int s;
    log_n = q30_log2(POW_TABLE_ENTRIES);
    roots[1] = int_sqrt(64'd1 << 61);
    for (int k = 2; k <= 30; k++) roots[k] = int_sqrt(roots[k-1] << 30);
    pow_q16[0] = 0;
    for (int i = 1; i <= POW_TABLE_ENTRIES; i++) begin
      l = q30_log2(2 * i) - log_n;
      if (l >= 0) e = (l * EXP_NUM) / EXP_DEN;
      else e = -(((-l) * EXP_NUM + (EXP_DEN - 1)) / EXP_DEN);
      ep = e + (64'sd8 <<< 30);
      ip = int'(ep >>> 30);
      frac = ep & ((64'sd1 <<< 30) - 1);
      acc = 64'd1 << 30;
      for (int k = 1; k <= 30; k++)
        if (((frac >> (30 - k)) & 64'd1) != 0) acc = (acc * roots[k]) >> 30;
      s = 22 - ip;
      if (s < 1) s = 1;
      if (s > 62) s = 62;
      pow_q16[i] = (acc + (64'd1 << (s - 1))) >> s;
    end
  endfunction

  function automatic logic signed [18:0] altitude_of(logic [20:0] p);
    longint unsigned rmax;
    longint unsigned den;
    longint unsigned r;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned w;
    longint unsigned y;
    longint prod;
    longint a;
    rmax = (64'd1 << (RATIO_FRAC_BITS + 1)) - 1;
    den = longint'(slp_pa) << 4;
    if (den == 0) r = rmax;
    else r = (longint'(p) << RATIO_FRAC_BITS) / den;
    if (r > rmax) r = rmax;
    pos = r * POW_TABLE_ENTRIES;
    idx = pos >> (RATIO_FRAC_BITS + 1);
    w = pos & rmax;
    if (idx >= POW_TABLE_ENTRIES) idx = POW_TABLE_ENTRIES - 1;
    y = pow_q16[idx] + (((pow_q16[idx+1] - pow_q16[idx]) * w) >> (RATIO_FRAC_BITS + 1));
    prod = longint'(ALT_SCALE_Q4) * (65536 - longint'(y));
    a = ((prod + 32768 + (64'sd1 <<< 44)) >>> 16) - (64'sd1 <<< 28);
    if (a < -65536) a = -65536;
    if (a > 262143) a = 262143;
    return a[18:0];
  endfunction

  function automatic alt_result_t next_altitude(logic [20:0] p, logic [31:0] t, logic failed);
    alt_result_t r;
    logic [31:0] dt;
    logic signed [18:0] a;
    longint v;
    dt = t - last_time;
    if (dt < {16'd0, min_gap_ms}) begin
      r.alt = last_alt;
      r.vel = last_vel;
      r.fresh = 1'b0;
      return r;
    end
    a = failed ? FAIL_ALT_Q4 : altitude_of(p);
    v = 0;
    if (dt != 0) begin
      v = ((longint'(a) - longint'(last_alt)) * 1000) / longint'(dt);
      if (v < -524288) v = -524288;
      if (v > 524287) v = 524287;
    end
    last_alt = a;
    last_time = t;
    last_vel = v[19:0];
    r.alt = a;
    r.vel = v[19:0];
    r.fresh = 1'b1;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // sender: returns right after the accepting edge
  task automatic push_request(logic [20:0] p, logic [31:0] t, logic failed);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, t, p};
    s_tuser <= failed;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SEA_LEVEL_PRESSURE) slp_pa = val;
    else if (idx == REG_MIN_INTERVAL_MS) min_gap_ms = val[15:0];
  endtask

  task automatic drain();
    wait (pending_results.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  // receiver
  initial begin
    int gap;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        m_tready <= 1'b0;
        repeat (stall_hold) @(negedge clk);
        stall_hold = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    alt_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser) fresh_seen++;
      else held_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if ($signed(m_tdata[18:0]) != want.alt)
          report("altitude_q4", $signed(m_tdata[18:0]), want.alt);
        if ($signed(m_tdata[38:19]) != want.vel)
          report("velocity_q4", $signed(m_tdata[38:19]), want.vel);
        if (m_tuser != want.fresh) report("fresh", m_tuser, want.fresh);
      end
    end
  end

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    directed_row_t rows [$];
    alt_result_t r;
    logic [31:0] t_now;
    logic [20:0] p;
    logic [31:0] step;
    logic [16:0] slp_set [N_PHASES] = '{17'd101520, 17'd131071, 17'd30000,
                                        17'd0, 17'd80000, 17'd120000};
    logic [15:0] gap_set [N_PHASES] = '{16'd45, 16'd0, 16'd65535, 16'd10, 16'd1, 16'd45};
    int sel;
    longint base;

    fill_pow_table();
    // failed read first, then a held one, then the high saturation ends,
    // then full-scale pressure driving velocity to its low end
    rows = '{
      '{21'd0, 32'd100, 1'b1, 1'b1, -19'sd16, -20'sd160, 1'b1},
      '{21'd0, 32'd120, 1'b0, 1'b1, -19'sd16, -20'sd160, 1'b0},
      '{21'd0, 32'd200, 1'b0, 1'b1, ALT_MAX, VEL_MAX, 1'b1},
      '{21'h1FFFFF, 32'd300, 1'b0, 1'b0, '0, '0, 1'b0},
      '{21'd1624320, 32'd400, 1'b0, 1'b0, '0, '0, 1'b0},
      '{21'd1600000, 32'd445, 1'b0, 1'b0, '0, '0, 1'b0},
      '{21'd1599000, 32'd489, 1'b0, 1'b0, '0, '0, 1'b0},
      '{21'd1500000, 32'd600, 1'b1, 1'b0, '0, '0, 1'b0},
      '{21'd1800000, 32'hFFFF_FF00, 1'b0, 1'b0, '0, '0, 1'b0},
      '{21'd1550000, 32'h0000_0040, 1'b0, 1'b0, '0, '0, 1'b0},
      '{21'd1000000, 32'h0000_1000, 1'b0, 1'b0, '0, '0, 1'b0},
      '{21'd1234567, 32'hAAAA_AAAA, 1'b0, 1'b0, '0, '0, 1'b0},
      '{21'd699050, 32'h5555_5555, 1'b0, 1'b0, '0, '0, 1'b0},
      '{21'd1620000, 32'h5555_5600, 1'b0, 1'b0, '0, '0, 1'b0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      push_request(rows[i].p, rows[i].t, rows[i].failed);
      r = next_altitude(rows[i].p, rows[i].t, rows[i].failed);
      if (rows[i].typed) begin
        r.alt = rows[i].alt;
        r.vel = rows[i].vel;
        r.fresh = rows[i].fresh;
      end
      pending_results.push_back(r);
    end
    t_now = rows[rows.size() - 1].t;
    drop_valid();
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 3) begin
        // writes to unused indexes must leave both registers alone
        write_reg(REG_SPARE_A, 17'h1FFFF);
        write_reg(REG_SPARE_B, 17'h00000);
      end
      write_reg(REG_SEA_LEVEL_PRESSURE, slp_set[ph]);
      write_reg(REG_MIN_INTERVAL_MS, {1'b0, gap_set[ph]});
      no_idle = (ph == 4);
      if (ph == 5) stall_hold = 400;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(0, 9);
        if (sel <= 5) step = min_gap_ms + $urandom_range(0, 200);
        else if (sel <= 7) step = $urandom_range(0, min_gap_ms);
        else if (sel == 8) step = $urandom;
        else step = min_gap_ms;
        t_now = t_now + step;
        if ($urandom_range(0, 9) < 7) begin
          base = longint'(slp_pa) * 16 + $urandom_range(0, 400000) - 200000;
          if (base < 0) base = 0;
          if (base > 2097151) base = 2097151;
          p = base[20:0];
        end else begin
          p = $urandom;
        end
        push_request(p, t_now, $urandom_range(0, 9) == 0);
        pending_results.push_back(next_altitude(p, t_now, s_tuser));
      end
      drop_valid();
      drain();
    end

    $display("%0d results checked (%0d updates, %0d held) over %0d register settings",
             results_seen, fresh_seen, held_seen, N_PHASES);
    $display("covered failed reads, time wrap, zero interval, zero and full-scale p0");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
